@@ rtl/sfp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfp_pkg
// Parse phases, sync and class bytes and event codes for the sync frame parser
// ----------------------------------------------------------------------------
package sfp_pkg;

  // parse phases
  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN1    = 4'd4;
  localparam logic [3:0] PH_LEN2    = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CKA     = 4'd7;
  localparam logic [3:0] PH_CKB     = 4'd8;

  // framing bytes
  localparam logic [7:0] SYNC_A     = 8'hB5;
  localparam logic [7:0] SYNC_B     = 8'h62;
  localparam logic [7:0] CLS_ACK    = 8'h05;
  localparam logic [7:0] ACK_ID_ACK = 8'h01;
  localparam logic [7:0] ACK_ID_NAK = 8'h00;
  localparam logic [7:0] DOLLAR     = 8'h24;

  // event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_GOOD    = 3'd2;
  localparam logic [2:0] EV_ACK     = 3'd3;
  localparam logic [2:0] EV_CKSUM   = 3'd4;
  localparam logic [2:0] EV_LENGTH  = 3'd5;

  localparam logic [15:0] LIMIT_RESET = 16'd512;

endpackage

@@ rtl/sync_frame_parser_fletcher8_top.sv @@
// ----------------------------------------------------------------------------
// sync_frame_parser_fletcher8_top
// Byte-serial sync frame parser with Fletcher-8 check, ack tracking, counters
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid / in_stall    | rx_byte
//  out      | out_valid / out_stall  | event_res .. dollar_count
//  cfg      | cfg_valid / cfg_ready  | payload_limit
//
//  one item per clock while in_stall is low: each byte updates the parse state
//  and its result sits in the output register the cycle after acceptance
//  the output register decouples the sides: a new item is taken while the
//  previous result is being taken, in_stall rises only if it is held
//  rst is synchronous, active high; parse returns to sync hunting, all
//  sums, counters and ack status clear, the payload limit goes to 512
//  cfg_ready is always high; write only while idle
//
module sync_frame_parser_fletcher8_top #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [7:0]  frame_class,
  output logic [7:0]  msg_id,
  output logic [15:0] msg_length,
  output logic        ack_ok,
  output logic [7:0]  acked_class,
  output logic [7:0]  acked_id,
  output logic [31:0] frame_count,
  output logic [31:0] error_count,
  output logic [31:0] dollar_count,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] payload_limit
);

  localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

  // configuration
  logic [15:0] limit;

  // parse state
  logic [3:0]  parse_phase, parse_phase_next;
  logic [7:0]  cur_class, cur_class_next;
  logic [7:0]  cur_id, cur_id_next;
  logic [15:0] cur_length, cur_length_next;
  logic [15:0] byte_index, byte_index_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [15:0] first_two_payload, first_two_payload_next;
  logic        ack_flag, ack_flag_next;
  logic [15:0] ack_target, ack_target_next;
  logic [COUNTER_WIDTH-1:0] good_frames, good_frames_next;
  logic [COUNTER_WIDTH-1:0] bad_frames, bad_frames_next;
  logic [COUNTER_WIDTH-1:0] dollars, dollars_next;

  // per-item result register
  logic [2:0]  ev, ev_next;
  logic [7:0]  pbyte, pbyte_next;
  logic [15:0] pindex, pindex_next;

  logic        accept;
  logic        good_inc, bad_inc;
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [16:0] index_plus;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  // running fletcher step on the incoming byte
  assign add_a      = sum_a + rx_byte;
  assign add_b      = sum_b + add_a;
  assign len_full   = {rx_byte, cur_length[7:0]};
  assign index_plus = {1'b0, byte_index} + 17'd1;

  always_comb begin
    parse_phase_next       = parse_phase;
    cur_class_next         = cur_class;
    cur_id_next            = cur_id;
    cur_length_next        = cur_length;
    byte_index_next        = byte_index;
    sum_a_next             = sum_a;
    sum_b_next             = sum_b;
    first_two_payload_next = first_two_payload;
    ack_flag_next          = ack_flag;
    ack_target_next        = ack_target;
    ev_next                = sfp_pkg::EV_NONE;
    pbyte_next             = 8'd0;
    pindex_next            = 16'd0;
    good_inc               = 1'b0;
    bad_inc                = 1'b0;

    case (parse_phase)
      sfp_pkg::PH_SYNC1: begin
        if (rx_byte == sfp_pkg::SYNC_A) begin
          parse_phase_next = sfp_pkg::PH_SYNC2;
        end
      end
      sfp_pkg::PH_SYNC2: begin
        // any other byte, a repeated first sync too, restarts the hunt
        parse_phase_next = (rx_byte == sfp_pkg::SYNC_B) ? sfp_pkg::PH_CLASS
                                                        : sfp_pkg::PH_SYNC1;
      end
      sfp_pkg::PH_CLASS: begin
        cur_class_next   = rx_byte;
        sum_a_next       = rx_byte;
        sum_b_next       = rx_byte;
        parse_phase_next = sfp_pkg::PH_ID;
      end
      sfp_pkg::PH_ID: begin
        cur_id_next      = rx_byte;
        sum_a_next       = add_a;
        sum_b_next       = add_b;
        parse_phase_next = sfp_pkg::PH_LEN1;
      end
      sfp_pkg::PH_LEN1: begin
        cur_length_next  = {8'd0, rx_byte};
        sum_a_next       = add_a;
        sum_b_next       = add_b;
        parse_phase_next = sfp_pkg::PH_LEN2;
      end
      sfp_pkg::PH_LEN2: begin
        cur_length_next = len_full;
        sum_a_next      = add_a;
        sum_b_next      = add_b;
        byte_index_next = 16'd0;
        if (len_full > limit) begin
          parse_phase_next = sfp_pkg::PH_SYNC1;
          bad_inc          = 1'b1;
          ev_next          = sfp_pkg::EV_LENGTH;
        end else if (len_full == 16'd0) begin
          parse_phase_next = sfp_pkg::PH_CKA;
        end else begin
          parse_phase_next = sfp_pkg::PH_PAYLOAD;
        end
      end
      sfp_pkg::PH_PAYLOAD: begin
        ev_next     = sfp_pkg::EV_PAYLOAD;
        pbyte_next  = rx_byte;
        pindex_next = byte_index;
        // first payload byte is the acked class, second the acked id
        if (byte_index == 16'd0) begin
          first_two_payload_next = {rx_byte, first_two_payload[7:0]};
        end else if (byte_index == 16'd1) begin
          first_two_payload_next = {first_two_payload[15:8], rx_byte};
        end
        sum_a_next = add_a;
        sum_b_next = add_b;
        if (index_plus >= {1'b0, cur_length}) begin
          parse_phase_next = sfp_pkg::PH_CKA;
        end
        byte_index_next = index_plus[15:0];
      end
      sfp_pkg::PH_CKA: begin
        if (rx_byte == sum_a) begin
          parse_phase_next = sfp_pkg::PH_CKB;
        end else begin
          parse_phase_next = sfp_pkg::PH_SYNC1;
          bad_inc          = 1'b1;
          ev_next          = sfp_pkg::EV_CKSUM;
        end
      end
      sfp_pkg::PH_CKB: begin
        parse_phase_next = sfp_pkg::PH_SYNC1;
        if (rx_byte == sum_b) begin
          good_inc = 1'b1;
          ev_next  = sfp_pkg::EV_GOOD;
          if (cur_class == sfp_pkg::CLS_ACK) begin
            ev_next = sfp_pkg::EV_ACK;
            if (cur_id == sfp_pkg::ACK_ID_ACK) begin
              ack_flag_next = 1'b1;
              if (cur_length >= 16'd2) begin
                ack_target_next = first_two_payload;
              end
            end else if (cur_id == sfp_pkg::ACK_ID_NAK) begin
              ack_flag_next = 1'b0;
            end
          end
        end else begin
          bad_inc = 1'b1;
          ev_next = sfp_pkg::EV_CKSUM;
        end
      end
      default: begin
        parse_phase_next = sfp_pkg::PH_SYNC1;
      end
    endcase
  end

  // saturating counters
  always_comb begin
    good_frames_next = good_frames;
    bad_frames_next  = bad_frames;
    dollars_next     = dollars;
    if (good_inc && (good_frames != CNT_MAX)) begin
      good_frames_next = good_frames + CNT_ONE;
    end
    if (bad_inc && (bad_frames != CNT_MAX)) begin
      bad_frames_next = bad_frames + CNT_ONE;
    end
    // dollar bytes count in every phase, inside frames too
    if ((rx_byte == sfp_pkg::DOLLAR) && (dollars != CNT_MAX)) begin
      dollars_next = dollars + CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= sfp_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= payload_limit;
    end
  end

  // state only moves on an accepted item, so it doubles as the held result
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= sfp_pkg::PH_SYNC1;
      cur_class         <= 8'd0;
      cur_id            <= 8'd0;
      cur_length        <= 16'd0;
      byte_index        <= 16'd0;
      sum_a             <= 8'd0;
      sum_b             <= 8'd0;
      first_two_payload <= 16'd0;
      ack_flag          <= 1'b0;
      ack_target        <= 16'd0;
      good_frames       <= '0;
      bad_frames        <= '0;
      dollars           <= '0;
    end else if (accept) begin
      parse_phase       <= parse_phase_next;
      cur_class         <= cur_class_next;
      cur_id            <= cur_id_next;
      cur_length        <= cur_length_next;
      byte_index        <= byte_index_next;
      sum_a             <= sum_a_next;
      sum_b             <= sum_b_next;
      first_two_payload <= first_two_payload_next;
      ack_flag          <= ack_flag_next;
      ack_target        <= ack_target_next;
      good_frames       <= good_frames_next;
      bad_frames        <= bad_frames_next;
      dollars           <= dollars_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev     <= ev_next;
      pbyte  <= pbyte_next;
      pindex <= pindex_next;
    end
  end

  assign event_res     = ev;
  assign payload_byte  = pbyte;
  assign payload_index = pindex;
  assign frame_class   = cur_class;
  assign msg_id        = cur_id;
  assign msg_length    = cur_length;
  assign ack_ok        = ack_flag;
  assign acked_class   = ack_target[15:8];
  assign acked_id      = ack_target[7:0];

  // counters are shown as 32 bits, zero-extended or truncated
  generate
    if (COUNTER_WIDTH >= 32) begin : g_cnt_trunc
      assign frame_count  = good_frames[31:0];
      assign error_count  = bad_frames[31:0];
      assign dollar_count = dollars[31:0];
    end else begin : g_cnt_ext
      assign frame_count  = {{(32-COUNTER_WIDTH){1'b0}}, good_frames};
      assign error_count  = {{(32-COUNTER_WIDTH){1'b0}}, bad_frames};
      assign dollar_count = {{(32-COUNTER_WIDTH){1'b0}}, dollars};
    end
  endgenerate

endmodule
